// File: hw/rtl/isc_pkg.sv
// Package for the insertion sort block: sizes, item and result words, states.
// Used by insertion_sort_with_counts, its checker and its testbench.
// No dependencies.
`default_nettype none

package isc_pkg;

    // Capacity of the element store
    localparam int MAX_ITEMS = 64;
    // Store index and fill count widths
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    // Field widths
    localparam int VAL_W = 32;
    localparam int TOT_W = 11;

    // Input word
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    is_last;
    } item_t;

    // Result word
    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
        logic [TOT_W-1:0]        compare_total;
        logic [TOT_W-1:0]        swap_total;
        logic                    overflow;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_RDKEY,
        S_KEY,
        S_CMP,
        S_PUT,
        S_OUT,
        S_FLUSH
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/insertion_sort_with_counts.sv
// Top level of the insertion sort block with comparison and swap totals.
// Depends on isc_pkg and isc_ram.
//
// channel  | handshake              | word
// ---------+------------------------+--------------------------------------
// item     | start high, busy low   | isc_pkg::item_t   (value, is_last)
// result   | strobe, one cycle      | isc_pkg::result_t (sorted value, totals)
//
// Loading takes one word per cycle; busy stays low until the last word.
// Sorting runs through one RAM port pair: each key passes S_RDKEY and S_KEY,
// then one S_CMP step per comparison, then S_PUT.
// Results come out back to back on consecutive cycles; the receiver cannot stall them.
// Reset clears control state only; the store is written before it is read.
`default_nettype none

module insertion_sort_with_counts (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire isc_pkg::item_t    item,
    output      logic              strobe,
    output      isc_pkg::result_t  result
);

    isc_pkg::state_t state_reg, state_next;

    logic [isc_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [isc_pkg::IDX_W-1:0] i_reg, i_next;
    logic [isc_pkg::IDX_W-1:0] j_reg, j_next;
    logic [isc_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [isc_pkg::IDX_W-1:0] k_reg, k_next;
    logic [isc_pkg::VAL_W-1:0] key_reg, key_next;
    logic [isc_pkg::TOT_W-1:0] cmp_reg, cmp_next;
    logic [isc_pkg::TOT_W-1:0] swp_reg, swp_next;
    logic                      strobe_reg, strobe_next;
    logic                      last_reg, last_next;

    logic                      wr_en;
    logic [isc_pkg::IDX_W-1:0] wr_addr;
    logic [isc_pkg::VAL_W-1:0] wr_data;
    logic [isc_pkg::IDX_W-1:0] rd_addr;
    logic [isc_pkg::VAL_W-1:0] rd_data;

    logic                      accept;
    logic                      has_room;
    logic [isc_pkg::CNT_W-1:0] count_after;
    logic                      key_less;
    logic                      i_done;
    logic                      k_done;

    // Element store
    isc_ram #(
        .WIDTH (isc_pkg::VAL_W),
        .DEPTH (isc_pkg::MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared decodes
    assign accept      = start && (state_reg == isc_pkg::S_LOAD);
    assign has_room    = (count_reg < isc_pkg::CNT_W'(isc_pkg::MAX_ITEMS));
    assign count_after = has_room ? (count_reg + isc_pkg::CNT_W'(1)) : count_reg;
    assign key_less    = $signed(key_reg) < $signed(rd_data);
    assign i_done      = ((isc_pkg::CNT_W'(i_reg) + isc_pkg::CNT_W'(1)) == count_reg);
    assign k_done      = ((isc_pkg::CNT_W'(k_reg) + isc_pkg::CNT_W'(1)) == count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isc_pkg::S_LOAD:
            begin
                if (start && item.is_last)
                begin
                    if (count_after > isc_pkg::CNT_W'(1))
                    begin
                        state_next = isc_pkg::S_RDKEY;
                    end
                    else
                    begin
                        state_next = isc_pkg::S_OUT;
                    end
                end
            end
            isc_pkg::S_RDKEY: state_next = isc_pkg::S_KEY;
            isc_pkg::S_KEY:   state_next = isc_pkg::S_CMP;
            isc_pkg::S_CMP:
            begin
                if (!key_less || (j_reg == '0))
                begin
                    state_next = isc_pkg::S_PUT;
                end
            end
            isc_pkg::S_PUT:
            begin
                state_next = i_done ? isc_pkg::S_OUT : isc_pkg::S_RDKEY;
            end
            isc_pkg::S_OUT:
            begin
                if (k_done)
                begin
                    state_next = isc_pkg::S_FLUSH;
                end
            end
            isc_pkg::S_FLUSH: state_next = isc_pkg::S_LOAD;
            default:          state_next = isc_pkg::S_LOAD;
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        key_next    = key_reg;
        cmp_next    = cmp_reg;
        swp_next    = swp_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[isc_pkg::IDX_W-1:0];
        wr_data     = item.value;
        rd_addr     = i_reg;
        case (state_reg)
            isc_pkg::S_LOAD:
            begin
                // Store the word if there is room, else flag the drop
                if (accept)
                begin
                    count_next = count_after;
                    if (has_room)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.is_last)
                    begin
                        cmp_next = '0;
                        swp_next = '0;
                        i_next   = isc_pkg::IDX_W'(1);
                        k_next   = '0;
                    end
                end
            end
            isc_pkg::S_RDKEY:
            begin
                // Fetch the key
                rd_addr = i_reg;
            end
            isc_pkg::S_KEY:
            begin
                // Hold the key, fetch its left neighbor
                key_next = rd_data;
                j_next   = i_reg - isc_pkg::IDX_W'(1);
                rd_addr  = i_reg - isc_pkg::IDX_W'(1);
            end
            isc_pkg::S_CMP:
            begin
                // Compare key with entry j; shift the entry right while greater
                cmp_next = (cmp_reg == '1) ? cmp_reg : cmp_reg + isc_pkg::TOT_W'(1);
                rd_addr  = j_reg - isc_pkg::IDX_W'(1);
                if (key_less)
                begin
                    swp_next = (swp_reg == '1) ? swp_reg : swp_reg + isc_pkg::TOT_W'(1);
                    wr_en    = 1'b1;
                    wr_addr  = j_reg + isc_pkg::IDX_W'(1);
                    wr_data  = rd_data;
                    if (j_reg == '0)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg - isc_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    pos_next = j_reg + isc_pkg::IDX_W'(1);
                end
            end
            isc_pkg::S_PUT:
            begin
                // Drop the key into its slot and advance
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = key_reg;
                i_next  = i_reg + isc_pkg::IDX_W'(1);
                k_next  = '0;
            end
            isc_pkg::S_OUT:
            begin
                // Read out in order; the word shows the cycle after
                rd_addr     = k_reg;
                strobe_next = 1'b1;
                last_next   = k_done;
                k_next      = k_reg + isc_pkg::IDX_W'(1);
            end
            isc_pkg::S_FLUSH:
            begin
                // Final word is on the ports; clear the run
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= isc_pkg::S_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            cmp_reg    <= '0;
            swp_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            cmp_reg    <= cmp_next;
            swp_reg    <= swp_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    // Key register
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // Ports
    assign busy                 = (state_reg != isc_pkg::S_LOAD);
    assign strobe               = strobe_reg;
    assign result.sorted_value  = rd_data;
    assign result.last_out      = last_reg;
    assign result.compare_total = cmp_reg;
    assign result.swap_total    = swp_reg;
    assign result.overflow      = ovf_reg;

endmodule

`default_nettype wire

// File: hw/rtl/isc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/isc_checker.sv
// Port-level checks for insertion_sort_with_counts, with its bind.
// Depends on isc_pkg.
`default_nettype none

module isc_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire isc_pkg::item_t   item,
    input wire logic             strobe,
    input wire isc_pkg::result_t result
);

    // A run's results come out back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_out |=> strobe)
        else $error("result burst broken before last word");

    // Nothing follows the last word of a run
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_out |=> !strobe)
        else $error("result after last word");

    // Results only while the block is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result while idle");

    // Totals and overflow hold across a run
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_out |=> $stable(result.compare_total)
            && $stable(result.swap_total) && $stable(result.overflow))
        else $error("totals changed within a run");

    // A last word closes the input
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.is_last |=> busy)
        else $error("input still open after last word");

endmodule

bind insertion_sort_with_counts isc_checker u_isc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

// File: verif/insertion_sort_with_counts_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sort_with_counts: loads lists of words, predicts
// the sorted output with comparison and swap totals, and checks every result word.
// Depends on isc_pkg and the insertion_sort_with_counts RTL.

module insertion_sort_with_counts_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_TAIL    = 40;
    localparam int TOT_MAX       = (1 << isc_pkg::TOT_W) - 1;
    localparam logic signed [isc_pkg::VAL_W-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [isc_pkg::VAL_W-1:0] VMIN = 32'sh80000000;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_RISING,
        SHAPE_FALLING
    } shape_e;

    typedef struct {
        isc_pkg::item_t word;
        bit             drain_first;
    } send_t;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    isc_pkg::item_t   item  = '0;
    logic             strobe;
    isc_pkg::result_t result;

    send_t            words_to_send[$];
    isc_pkg::result_t sorted_due[$];

    // Predictor copy of the element store
    logic signed [isc_pkg::VAL_W-1:0] held_vals [isc_pkg::MAX_ITEMS];
    int held_count   = 0;
    bit held_dropped = 1'b0;

    bit word_taken     = 1'b0;
    int gap_left       = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int lists_done     = 0;
    int overflow_lists = 0;

    insertion_sort_with_counts u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Store one accepted word; on the last word sort and queue the result words
    task automatic absorb_word(input isc_pkg::item_t w);
        int i, j, cmp_n, swp_n;
        bit moving;
        logic signed [isc_pkg::VAL_W-1:0] t;
        isc_pkg::result_t r;
        if (held_count < isc_pkg::MAX_ITEMS)
        begin
            held_vals[held_count] = w.value;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (w.is_last)
        begin
            cmp_n = 0;
            swp_n = 0;
            for (i = 1; i < held_count; i++)
            begin
                j = i;
                moving = 1'b1;
                while (j > 0 && moving)
                begin
                    cmp_n++;
                    if (held_vals[j] < held_vals[j-1])
                    begin
                        t = held_vals[j];
                        held_vals[j] = held_vals[j-1];
                        held_vals[j-1] = t;
                        swp_n++;
                        j--;
                    end
                    else
                        moving = 1'b0;
                end
            end
            for (i = 0; i < held_count; i++)
            begin
                r.sorted_value  = held_vals[i];
                r.last_out      = (i == held_count - 1);
                r.compare_total = isc_pkg::TOT_W'((cmp_n > TOT_MAX) ? TOT_MAX : cmp_n);
                r.swap_total    = isc_pkg::TOT_W'((swp_n > TOT_MAX) ? TOT_MAX : swp_n);
                r.overflow      = held_dropped;
                sorted_due = {sorted_due, r};
            end
            lists_done++;
            if (held_dropped)
                overflow_lists++;
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    task automatic push_word(input logic signed [isc_pkg::VAL_W-1:0] v, input bit last,
                             input bit drain);
        send_t s;
        s.word.value   = v;
        s.word.is_last = last;
        s.drain_first  = drain;
        words_to_send = {words_to_send, s};
    endtask

    function automatic logic signed [isc_pkg::VAL_W-1:0] pick_value();
        logic signed [isc_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = VMIN + $urandom_range(0, 2);
            1:       v = VMAX - $urandom_range(0, 2);
            2, 3:    v = $urandom_range(0, 16) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Queue one list of n words with the given ordering
    task automatic add_list(input int n, input shape_e shape, input bit drain);
        logic signed [isc_pkg::VAL_W-1:0] v, step;
        int k;
        v = pick_value();
        step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5000);
        for (k = 0; k < n; k++)
        begin
            case (shape)
                SHAPE_RANDOM:  v = pick_value();
                SHAPE_RISING:  if (k > 0) v = v + step;
                SHAPE_FALLING: if (k > 0) v = v - step;
            endcase
            push_word(v, k == n - 1, drain && k == 0);
        end
    endtask

    function automatic int small_size();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
    endfunction

    // Drive item words at the falling edge
    always @(negedge clk)
    begin
        logic           next_start;
        isc_pkg::item_t next_word;
        next_start = start;
        next_word  = item;
        if (!rst_n)
            next_start = 1'b0;
        else if (start && !word_taken)
            next_start = 1'b1;
        else if (gap_left > 0)
        begin
            next_start = 1'b0;
            gap_left--;
        end
        else if (words_to_send.size() == 0)
            next_start = 1'b0;
        else if (words_to_send[0].drain_first && sorted_due.size() != 0)
            next_start = 1'b0;
        else if (words_to_send.size() > QUIET_TAIL && ((words_to_send.size() / 50) % 3) != 2
                 && $urandom_range(0, 4) == 0)
        begin
            gap_left   = $urandom_range(1, 13) - 1;
            next_start = 1'b0;
        end
        else
        begin
            next_start = 1'b1;
            next_word  = words_to_send[0].word;
        end
        start <= next_start;
        item  <= next_word;
    end

    // Check result words and take accepted item words at the rising edge
    always @(posedge clk)
    begin
        isc_pkg::result_t want;
        bit took;
        took = 1'b0;
        if (rst_n)
            cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d result words outstanding",
                     $time, cycle_count, sorted_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            if (rst_n && strobe)
            begin
                results_seen++;
                if (sorted_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result word: expected none, actual value %0d",
                             $time, result.sorted_value);
                end
                else
                begin
                    want = sorted_due.pop_front();
                    check_field("sorted_value", want.sorted_value, result.sorted_value);
                    check_field("last_out", want.last_out, result.last_out);
                    check_field("compare_total", want.compare_total, result.compare_total);
                    check_field("swap_total", want.swap_total, result.swap_total);
                    check_field("overflow", want.overflow, result.overflow);
                end
            end
            if (rst_n && start && !busy)
            begin
                absorb_word(item);
                void'(words_to_send.pop_front());
                words_sent++;
                took = 1'b1;
            end
        end
        word_taken <= took;
    end

    initial
    begin
        int k;
        // Directed lists: single extreme, full-range mix, duplicates, ordered, reversed, bits
        push_word(VMIN, 1'b1, 1'b0);
        push_word(VMAX, 1'b0, 1'b0);
        push_word(0, 1'b0, 1'b0);
        push_word(-1, 1'b0, 1'b0);
        push_word(VMIN, 1'b0, 1'b0);
        push_word(1, 1'b1, 1'b0);
        push_word(7, 1'b0, 1'b0);
        push_word(7, 1'b0, 1'b0);
        push_word(7, 1'b1, 1'b0);
        push_word(-2, 1'b0, 1'b0);
        push_word(-1, 1'b0, 1'b0);
        push_word(3, 1'b0, 1'b0);
        push_word(9, 1'b1, 1'b0);
        push_word(40, 1'b0, 1'b0);
        push_word(-3, 1'b0, 1'b0);
        push_word(-3, 1'b0, 1'b0);
        push_word(-100, 1'b1, 1'b0);
        push_word(32'sh55555555, 1'b0, 1'b0);
        push_word(32'shAAAAAAAA, 1'b0, 1'b0);
        push_word(32'sh0000FFFF, 1'b1, 1'b0);

        // Fill the store in strictly falling order for the largest totals
        for (k = 0; k < isc_pkg::MAX_ITEMS; k++)
            push_word(isc_pkg::MAX_ITEMS - 1 - k, k == isc_pkg::MAX_ITEMS - 1, k == 0);

        // Random small lists, then one list past capacity, then more small lists
        while (words_to_send.size() < 200)
            add_list(small_size(), shape_e'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);
        add_list(isc_pkg::MAX_ITEMS + 2, SHAPE_RANDOM, 1'b1);
        while (words_to_send.size() < 380)
            add_list(small_size(), shape_e'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);

        // Hold reset, then release away from the sampling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() != 0 || sorted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d lists (%0d lists with dropped words),",
                 words_sent, lists_done, overflow_lists);
        $display("%0d results checked; covered value extremes, duplicates, ordered and",
                 results_seen);
        $display("reversed lists, and a full store.");
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
